// ===== hdl/ast_pkg.sv =====
// shared types and constants for the attained-service tracker
package ast_pkg;

  localparam int CNT_W     = 32;
  localparam int AS_W      = 48;
  localparam int WGT_W     = 16;
  localparam int QLEN_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int OP_W      = 2;
  localparam int TID_IN_W  = 4;

  // op codes
  localparam logic [OP_W-1:0] OP_SERVICE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_WEIGHT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SVC,
    ST_QRY,
    ST_WRD,
    ST_WCHK,
    ST_WMAC,
    ST_WEND
  } state_t;

  // table access request from the sequencer
  typedef struct packed {
    logic rd;
    logic cnt_we;
    logic as_we;
    logic cnt_clr;
  } store_req_t;

endpackage

// ===== hdl/attained_service_tracker_top.sv =====
// top level of the attained-service tracker: sequencer, tick counter, config
//
// Per-thread attained-service bookkeeping for a least-attained-service memory
// scheduler. An item is taken when start is high and busy is low. A service
// item (op 0) bumps the thread's saturating 32-bit count for this quantum and
// keeps busy high for one cycle. A tick item (op 1) advances the tick counter;
// if it does not end the quantum, busy stays low and the next item can follow
// at once. A query item (op 2) keeps busy high for one cycle and its result,
// the thread's attained service in unsigned Q32.16, is strobed on out_valid
// for one cycle in the cycle after that; a thread at or above NUM_THREADS
// reads zero. There is no back-pressure on the result: out_valid is a plain
// one-cycle strobe that must be caught when it comes. A tick that ends the
// quantum starts a walk over all threads that holds busy high: the tables sit
// in one-read-port memories and the decay update runs on a single shared
// 17x32 multiplier, so a thread with a zero count takes a read and a check,
// one with a nonzero count takes a read, a check, four multiplier steps and a
// write-back, and a final state clears all counts at the end. Configuration
// writes must only be issued while busy is low; they take effect at once and
// never touch the tick counter.
module attained_service_tracker_top #(
  parameter int NUM_THREADS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [ast_pkg::OP_W-1:0]          in_op,
  input  logic [ast_pkg::TID_IN_W-1:0]      in_thread_id,
  // result channel
  output logic                              out_valid,
  output logic [ast_pkg::AS_W-1:0]          out_attained_service,
  // configuration port
  input  logic                              cfg_we,
  input  logic [ast_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ast_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int TID_W = $clog2(NUM_THREADS);

  // sequencer state
  ast_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic [ast_pkg::WGT_W-1:0]  decay_weight_r;
  logic [ast_pkg::QLEN_W-1:0] quantum_length_r;

  // tick counter and walk / item index
  logic [ast_pkg::CNT_W-1:0]  tick_r, tick_nxt;
  logic [ast_pkg::CNT_W-1:0]  tick_inc;
  logic                       quantum_end;
  logic [TID_W-1:0]           widx_r, widx_nxt;
  logic                       qry_ok_r, qry_ok_nxt;
  logic                       walk_last;

  // result register
  logic                       out_valid_r, out_valid_nxt;
  logic [ast_pkg::AS_W-1:0]   out_as_r, out_as_nxt;

  // incoming item decode
  logic                       accept;
  logic                       id_ok;
  logic [TID_W-1:0]           id_idx;

  // table and multiply-add unit hookup
  ast_pkg::store_req_t        store_req;
  logic [TID_W-1:0]           st_addr;
  logic [ast_pkg::CNT_W-1:0]  cnt_wdata;
  logic [ast_pkg::CNT_W-1:0]  cnt_rdata;
  logic [ast_pkg::AS_W-1:0]   as_rdata;
  logic                       mac_start;
  logic                       mac_run;
  logic                       mac_done;
  logic [ast_pkg::AS_W-1:0]   mac_result;

  assign busy   = (state_r != ast_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign id_ok  = (32'(in_thread_id) < NUM_THREADS);
  assign id_idx = TID_W'(in_thread_id);

  // tick counter saturates, quantum ends once it reaches the length
  assign tick_inc    = (tick_r == '1) ? tick_r : tick_r + ast_pkg::CNT_W'(1);
  assign quantum_end = (tick_inc >= quantum_length_r);
  assign walk_last   = (widx_r == TID_W'(NUM_THREADS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ast_pkg::ST_IDLE: begin
        if (start) begin
          case (in_op)
            ast_pkg::OP_SERVICE: begin
              if (id_ok) begin
                state_nxt = ast_pkg::ST_SVC;
              end
            end
            ast_pkg::OP_TICK: begin
              if (quantum_end) begin
                state_nxt = ast_pkg::ST_WRD;
              end
            end
            ast_pkg::OP_QUERY: begin
              state_nxt = ast_pkg::ST_QRY;
            end
            default: begin
            end
          endcase
        end
      end
      ast_pkg::ST_SVC: begin
        state_nxt = ast_pkg::ST_IDLE;
      end
      ast_pkg::ST_QRY: begin
        state_nxt = ast_pkg::ST_IDLE;
      end
      ast_pkg::ST_WRD: begin
        state_nxt = ast_pkg::ST_WCHK;
      end
      ast_pkg::ST_WCHK: begin
        if (cnt_rdata != '0) begin
          state_nxt = ast_pkg::ST_WMAC;
        end else if (walk_last) begin
          state_nxt = ast_pkg::ST_WEND;
        end else begin
          state_nxt = ast_pkg::ST_WRD;
        end
      end
      ast_pkg::ST_WMAC: begin
        if (mac_done) begin
          state_nxt = walk_last ? ast_pkg::ST_WEND : ast_pkg::ST_WRD;
        end
      end
      ast_pkg::ST_WEND: begin
        state_nxt = ast_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ast_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    store_req     = '0;
    st_addr       = widx_r;
    cnt_wdata     = cnt_rdata + ast_pkg::CNT_W'(1);
    mac_start     = 1'b0;
    tick_nxt      = tick_r;
    widx_nxt      = widx_r;
    qry_ok_nxt    = qry_ok_r;
    out_valid_nxt = 1'b0;
    out_as_nxt    = out_as_r;
    case (state_r)
      ast_pkg::ST_IDLE: begin
        if (start) begin
          st_addr = id_idx;
          case (in_op)
            ast_pkg::OP_SERVICE: begin
              store_req.rd = id_ok;
              widx_nxt     = id_idx;
            end
            ast_pkg::OP_TICK: begin
              tick_nxt = quantum_end ? '0 : tick_inc;
              widx_nxt = '0;
            end
            ast_pkg::OP_QUERY: begin
              store_req.rd = id_ok;
              widx_nxt     = id_idx;
              qry_ok_nxt   = id_ok;
            end
            default: begin
            end
          endcase
        end
      end
      ast_pkg::ST_SVC: begin
        // count holds at its maximum
        store_req.cnt_we = (cnt_rdata != '1);
      end
      ast_pkg::ST_QRY: begin
        out_valid_nxt = 1'b1;
        out_as_nxt    = qry_ok_r ? as_rdata : '0;
      end
      ast_pkg::ST_WRD: begin
        store_req.rd = 1'b1;
      end
      ast_pkg::ST_WCHK: begin
        // idle threads keep their attained service untouched
        if (cnt_rdata != '0) begin
          mac_start = 1'b1;
        end else if (!walk_last) begin
          widx_nxt = widx_r + TID_W'(1);
        end
      end
      ast_pkg::ST_WMAC: begin
        if (mac_done) begin
          store_req.as_we = 1'b1;
          if (!walk_last) begin
            widx_nxt = widx_r + TID_W'(1);
          end
        end
      end
      ast_pkg::ST_WEND: begin
        store_req.cnt_clr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ast_pkg::ST_IDLE;
      decay_weight_r   <= ast_pkg::WGT_W'(57344);
      quantum_length_r <= ast_pkg::QLEN_W'(10000000);
      tick_r           <= '0;
      widx_r           <= '0;
      qry_ok_r         <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      widx_r      <= widx_nxt;
      qry_ok_r    <= qry_ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ast_pkg::CFG_DECAY_WEIGHT: begin
            decay_weight_r <= cfg_wdata[ast_pkg::WGT_W-1:0];
          end
          ast_pkg::CFG_QUANTUM_LENGTH: begin
            quantum_length_r <= cfg_wdata[ast_pkg::QLEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_as_r <= out_as_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_attained_service = out_as_r;

  ast_store #(
    .NUM_THREADS (NUM_THREADS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (store_req),
    .addr      (st_addr),
    .cnt_wdata (cnt_wdata),
    .as_wdata  (mac_result),
    .cnt_rdata (cnt_rdata),
    .as_rdata  (as_rdata)
  );

  // operands stay put in the store's read registers while the unit runs
  ast_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mac_start),
    .weight (decay_weight_r),
    .as_val (as_rdata),
    .count  (cnt_rdata),
    .run    (mac_run),
    .done   (mac_done),
    .result (mac_result)
  );

  // a result strobe only ever follows a query cycle
  a_out_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ast_pkg::ST_QRY)
    else $error("result strobe without a query");

  // counts are only written by a service transfer
  a_cnt_we_svc: assert property (@(posedge clk) disable iff (!rst_n)
    store_req.cnt_we |-> state_r == ast_pkg::ST_SVC)
    else $error("count write outside service");

  // the multiply-add unit only runs while the walk waits on it
  a_mac_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    mac_run |-> state_r == ast_pkg::ST_WMAC)
    else $error("multiply-add running outside walk");

  // attained service is written back only with a fresh update result
  a_as_we_done: assert property (@(posedge clk) disable iff (!rst_n)
    store_req.as_we |-> mac_done)
    else $error("attained service written without update");

  // a tick that ends the quantum starts the walk
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == ast_pkg::OP_TICK && quantum_end) |=> state_r == ast_pkg::ST_WRD)
    else $error("quantum end did not start the walk");

endmodule

// ===== hdl/ast_mac.sv =====
// shared multiply-add unit for the attained-service decay update
module ast_mac (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ast_pkg::WGT_W-1:0]   weight,
  input  logic [ast_pkg::AS_W-1:0]    as_val,
  input  logic [ast_pkg::CNT_W-1:0]   count,
  output logic                        run,
  output logic                        done,
  output logic [ast_pkg::AS_W-1:0]    result
);

  localparam int MUL_A_W = ast_pkg::WGT_W + 1;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int HALF_W  = ast_pkg::AS_W / 2;
  localparam int ACC_W   = ast_pkg::WGT_W + ast_pkg::AS_W;
  localparam int SUM_W   = PROD_W + 1;

  localparam logic [1:0] STEP_LO    = 2'd0;
  localparam logic [1:0] STEP_HI    = 2'd1;
  localparam logic [1:0] STEP_FRESH = 2'd2;
  localparam logic [1:0] STEP_SUM   = 2'd3;

  logic                  run_r, run_nxt;
  logic [1:0]            step_r, step_nxt;
  logic                  done_r, done_nxt;
  logic [PROD_W-1:0]     prod_r;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [ast_pkg::AS_W-1:0] result_r, result_nxt;

  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [PROD_W-1:0]     mul;
  logic [SUM_W-1:0]      sum;

  // operand select for the one multiplier
  always_comb begin
    mul_a = {1'b0, weight};
    mul_b = {{(MUL_B_W-HALF_W){1'b0}}, as_val[HALF_W-1:0]};
    case (step_r)
      STEP_LO: begin
        mul_b = {{(MUL_B_W-HALF_W){1'b0}}, as_val[HALF_W-1:0]};
      end
      STEP_HI: begin
        mul_b = {{(MUL_B_W-HALF_W){1'b0}}, as_val[ast_pkg::AS_W-1:HALF_W]};
      end
      default: begin
        // weight of the fresh count is one minus alpha
        mul_a = MUL_A_W'(17'd65536) - {1'b0, weight};
        mul_b = count;
      end
    endcase
  end

  assign mul = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

  // rounded history plus fresh service
  assign sum = {2'b00, acc_r[ACC_W-1:ast_pkg::WGT_W]} + SUM_W'(prod_r);

  always_comb begin
    run_nxt    = run_r;
    step_nxt   = step_r;
    done_nxt   = 1'b0;
    acc_nxt    = acc_r;
    result_nxt = result_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = STEP_LO;
    end else if (run_r) begin
      step_nxt = step_r + 2'd1;
      case (step_r)
        STEP_HI: begin
          acc_nxt = ACC_W'(prod_r) + ACC_W'(32768);
        end
        STEP_FRESH: begin
          acc_nxt = acc_r + {prod_r[ast_pkg::WGT_W+HALF_W-1:0], {HALF_W{1'b0}}};
        end
        STEP_SUM: begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
          if (sum[SUM_W-1:ast_pkg::AS_W] != '0) begin
            result_nxt = '1;
          end else begin
            result_nxt = sum[ast_pkg::AS_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= STEP_LO;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= mul;
    acc_r    <= acc_nxt;
    result_r <= result_nxt;
  end

  assign run    = run_r;
  assign done   = done_r;
  assign result = result_r;

endmodule

// ===== hdl/ast_store.sv =====
// per-thread service count and attained-service tables with valid bits
module ast_store #(
  parameter int NUM_THREADS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ast_pkg::store_req_t               req,
  input  logic [$clog2(NUM_THREADS)-1:0]    addr,
  input  logic [ast_pkg::CNT_W-1:0]         cnt_wdata,
  input  logic [ast_pkg::AS_W-1:0]          as_wdata,
  output logic [ast_pkg::CNT_W-1:0]         cnt_rdata,
  output logic [ast_pkg::AS_W-1:0]          as_rdata
);

  logic [ast_pkg::CNT_W-1:0] cnt_mem [NUM_THREADS];
  logic [ast_pkg::AS_W-1:0]  as_mem  [NUM_THREADS];

  logic [NUM_THREADS-1:0]    cnt_vld_r;
  logic [NUM_THREADS-1:0]    as_vld_r;
  logic                      cnt_rv_r;
  logic                      as_rv_r;
  logic [ast_pkg::CNT_W-1:0] cnt_q_r;
  logic [ast_pkg::AS_W-1:0]  as_q_r;

  always_ff @(posedge clk) begin
    if (req.cnt_we) begin
      cnt_mem[addr] <= cnt_wdata;
    end
    if (req.as_we) begin
      as_mem[addr] <= as_wdata;
    end
    if (req.rd) begin
      cnt_q_r <= cnt_mem[addr];
      as_q_r  <= as_mem[addr];
    end
  end

  // unwritten entries read as zero; quantum ends clear only the counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
      as_vld_r  <= '0;
      cnt_rv_r  <= 1'b0;
      as_rv_r   <= 1'b0;
    end else begin
      if (req.cnt_clr) begin
        cnt_vld_r <= '0;
      end else if (req.cnt_we) begin
        cnt_vld_r[addr] <= 1'b1;
      end
      if (req.as_we) begin
        as_vld_r[addr] <= 1'b1;
      end
      if (req.rd) begin
        cnt_rv_r <= cnt_vld_r[addr];
        as_rv_r  <= as_vld_r[addr];
      end
    end
  end

  assign cnt_rdata = cnt_rv_r ? cnt_q_r : '0;
  assign as_rdata  = as_rv_r  ? as_q_r  : '0;

endmodule

// ===== sim/tb_attained_service_tracker_top.sv =====
// self-checking testbench for the attained-service tracker top level
`timescale 1ns / 1ps

module tb_attained_service_tracker_top;

  localparam int THREADS = 16;
  // longest busy stretch of a quantum-end walk, plus margin
  localparam int DRAIN_CYCLES = 7 * THREADS + 2;
  localparam int STALL_LIMIT = 1000;
  localparam logic [ast_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [63:0] AS_SAT = (64'd1 << ast_pkg::AS_W) - 64'd1;

  typedef enum logic {STIM_ITEM, STIM_CFG} stim_kind_t;

  typedef struct {
    stim_kind_t                        kind;
    logic [ast_pkg::OP_W-1:0]          op;
    logic [ast_pkg::TID_IN_W-1:0]      tid;
    int unsigned                       gap;
    logic [ast_pkg::CFG_IDX_W-1:0]     reg_idx;
    logic [ast_pkg::CFG_W-1:0]         reg_val;
  } stim_t;

  // dut-facing signals, all known from time zero
  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic [ast_pkg::OP_W-1:0]          in_op = ast_pkg::OP_SERVICE;
  logic [ast_pkg::TID_IN_W-1:0]      in_thread_id = '0;
  logic                              cfg_we = 1'b0;
  logic [ast_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [ast_pkg::CFG_W-1:0]         cfg_wdata = '0;
  logic                              busy;
  logic                              out_valid;
  logic [ast_pkg::AS_W-1:0]          out_attained_service;

  // stimulus and bookkeeping
  stim_t                             stim_q[$];
  logic [ast_pkg::AS_W-1:0]          as_answers_q[$];
  logic                              in_took = 1'b0;
  int unsigned                       gap_left = 0;
  int unsigned                       settle_left = DRAIN_CYCLES;
  int unsigned                       mismatches = 0;
  int unsigned                       items_taken = 0;
  int unsigned                       results_seen = 0;
  int unsigned                       quantum_ends = 0;
  int unsigned                       reg_writes = 0;
  int unsigned                       stall_cycles = 0;

  // predicted state of the tracker
  logic [ast_pkg::WGT_W-1:0]         decay_w;
  logic [ast_pkg::QLEN_W-1:0]        quantum_len;
  logic [ast_pkg::CNT_W-1:0]         tick_cnt;
  logic [ast_pkg::CNT_W-1:0]         svc_count[THREADS];
  logic [ast_pkg::AS_W-1:0]          as_book[THREADS];

  attained_service_tracker_top #(
    .NUM_THREADS(THREADS)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_op                (in_op),
    .in_thread_id         (in_thread_id),
    .out_valid            (out_valid),
    .out_attained_service (out_attained_service),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always #6 clk = ~clk;

  task automatic flag_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // apply one accepted command to the predicted state, queue any query answer
  function automatic void update_service_book(input logic [ast_pkg::OP_W-1:0] op,
                                              input logic [ast_pkg::TID_IN_W-1:0] tid);
    logic [63:0] hist;
    logic [63:0] fresh;
    logic [63:0] sum;
    case (op)
      ast_pkg::OP_SERVICE: begin
        if (svc_count[tid] != '1) svc_count[tid] = svc_count[tid] + 1'b1;
      end
      ast_pkg::OP_TICK: begin
        if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= quantum_len) begin
          // quantum end: decay busy threads, idle threads keep their value
          tick_cnt = '0;
          quantum_ends++;
          for (int t = 0; t < THREADS; t++) begin
            if (svc_count[t] != '0) begin
              hist  = (64'(decay_w) * 64'(as_book[t]) + 64'd32768) >> 16;
              fresh = (64'd65536 - 64'(decay_w)) * 64'(svc_count[t]);
              sum   = hist + fresh;
              as_book[t] = (sum > AS_SAT) ? AS_SAT[ast_pkg::AS_W-1:0]
                                          : sum[ast_pkg::AS_W-1:0];
            end
            svc_count[t] = '0;
          end
        end
      end
      ast_pkg::OP_QUERY: as_answers_q.push_back(as_book[tid]);
      default: ;
    endcase
  endfunction

  function automatic void push_item(input logic [ast_pkg::OP_W-1:0] op,
                                    input logic [ast_pkg::TID_IN_W-1:0] tid,
                                    input int unsigned gap);
    stim_t s;
    s.kind = STIM_ITEM;
    s.op = op;
    s.tid = tid;
    s.gap = gap;
    s.reg_idx = '0;
    s.reg_val = '0;
    stim_q.push_back(s);
  endfunction

  function automatic void push_cfg(input logic [ast_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [ast_pkg::CFG_W-1:0] val);
    stim_t s;
    s.kind = STIM_CFG;
    s.op = ast_pkg::OP_SERVICE;
    s.tid = '0;
    s.gap = 0;
    s.reg_idx = idx;
    s.reg_val = val;
    stim_q.push_back(s);
  endfunction

  // one phase of random traffic; hot threads let counts build up
  function automatic void push_random_phase(input int unsigned n_items);
    int unsigned r;
    logic [ast_pkg::OP_W-1:0] op;
    logic [ast_pkg::TID_IN_W-1:0] tid;
    bit no_gaps;
    no_gaps = 1'b0;
    for (int unsigned i = 0; i < n_items; i++) begin
      // flip between gapped traffic and back-to-back stretches
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 50) op = ast_pkg::OP_SERVICE;
      else if (r < 72) op = ast_pkg::OP_TICK;
      else if (r < 95) op = ast_pkg::OP_QUERY;
      else op = OP_UNUSED;
      if ($urandom_range(0, 1) == 0) tid = ast_pkg::TID_IN_W'($urandom_range(0, 3));
      else tid = ast_pkg::TID_IN_W'($urandom_range(0, THREADS - 1));
      push_item(op, tid, no_gaps ? 0 : $urandom_range(0, 3));
    end
  endfunction

  // driver: commands and register writes change on the falling edge
  always @(negedge clk) begin : drive
    logic nxt_start;
    logic nxt_we;
    logic [ast_pkg::OP_W-1:0] nxt_op;
    logic [ast_pkg::TID_IN_W-1:0] nxt_tid;
    logic [ast_pkg::CFG_IDX_W-1:0] nxt_idx;
    logic [ast_pkg::CFG_W-1:0] nxt_data;
    stim_t head;
    nxt_start = start;
    nxt_we = 1'b0;
    nxt_op = in_op;
    nxt_tid = in_thread_id;
    nxt_idx = cfg_index;
    nxt_data = cfg_wdata;
    if (rst_n) begin
      // the command held up went across at the last rising edge
      if (start && in_took) nxt_start = 1'b0;
      if (!nxt_start) begin
        if (stim_q.size() != 0 && stim_q[0].kind == STIM_CFG) begin
          // register writes only once the block has gone quiet
          if (busy || start || as_answers_q.size() != 0) begin
            settle_left = DRAIN_CYCLES;
          end else if (settle_left != 0) begin
            settle_left--;
          end else begin
            head = stim_q.pop_front();
            nxt_we = 1'b1;
            nxt_idx = head.reg_idx;
            nxt_data = head.reg_val;
          end
        end else if (gap_left != 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          head = stim_q.pop_front();
          nxt_start = 1'b1;
          nxt_op = head.op;
          nxt_tid = head.tid;
          gap_left = head.gap;
          settle_left = DRAIN_CYCLES;
        end
      end
    end
    start <= nxt_start;
    cfg_we <= nxt_we;
    in_op <= nxt_op;
    in_thread_id <= nxt_tid;
    cfg_index <= nxt_idx;
    cfg_wdata <= nxt_data;
  end

  // monitor: results, register writes and command transfers at the rising edge
  always @(posedge clk) begin : watch
    logic [ast_pkg::AS_W-1:0] want;
    if (!rst_n) begin
      decay_w = 16'd57344;
      quantum_len = 32'd10000000;
      tick_cnt = '0;
      for (int t = 0; t < THREADS; t++) begin
        svc_count[t] = '0;
        as_book[t] = '0;
      end
      in_took <= 1'b0;
    end else begin
      // a result always belongs to a query taken at an earlier edge
      if (out_valid) begin
        if (as_answers_q.size() == 0) begin
          flag_mismatch($sformatf("result %0h with no query outstanding",
                                  out_attained_service));
        end else begin
          want = as_answers_q.pop_front();
          results_seen++;
          if (out_attained_service !== want)
            flag_mismatch($sformatf("attained_service got %0h want %0h",
                                    out_attained_service, want));
        end
      end
      if (cfg_we) begin
        reg_writes++;
        case (cfg_index)
          ast_pkg::CFG_DECAY_WEIGHT:   decay_w = cfg_wdata[ast_pkg::WGT_W-1:0];
          ast_pkg::CFG_QUANTUM_LENGTH: quantum_len = cfg_wdata[ast_pkg::QLEN_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        update_service_book(in_op, in_thread_id);
        items_taken++;
      end
      in_took <= start && !busy;
    end
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || cfg_we) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("attained_service_tracker_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    // directed: reset contents, unused op, idle thread, weight and length extremes
    push_item(ast_pkg::OP_QUERY, 4'd0, 0);
    push_item(ast_pkg::OP_QUERY, 4'd15, 1);
    push_item(OP_UNUSED, 4'd5, 0);
    push_item(ast_pkg::OP_SERVICE, 4'd0, 0);
    push_item(ast_pkg::OP_SERVICE, 4'd0, 2);
    push_item(ast_pkg::OP_SERVICE, 4'd0, 0);
    push_item(ast_pkg::OP_SERVICE, 4'd15, 3);
    push_item(ast_pkg::OP_TICK, 4'd10, 0);
    push_item(ast_pkg::OP_QUERY, 4'd0, 0);
    // length lowered to the running tick count: next tick ends the quantum
    push_cfg(ast_pkg::CFG_DECAY_WEIGHT, 32'd0);
    push_cfg(ast_pkg::CFG_QUANTUM_LENGTH, 32'd1);
    push_item(ast_pkg::OP_TICK, 4'd3, 0);
    push_item(ast_pkg::OP_QUERY, 4'd0, 1);
    push_item(ast_pkg::OP_QUERY, 4'd15, 0);
    push_item(ast_pkg::OP_QUERY, 4'd7, 0);
    // full history weight
    push_cfg(ast_pkg::CFG_DECAY_WEIGHT, 32'h0000_FFFF);
    push_item(ast_pkg::OP_SERVICE, 4'd0, 0);
    push_item(ast_pkg::OP_TICK, 4'd0, 0);
    push_item(ast_pkg::OP_QUERY, 4'd0, 0);
    // zero length also ends on the next tick
    push_cfg(ast_pkg::CFG_QUANTUM_LENGTH, 32'd0);
    push_item(ast_pkg::OP_SERVICE, 4'd15, 0);
    push_item(ast_pkg::OP_SERVICE, 4'd15, 0);
    push_item(ast_pkg::OP_TICK, 4'd15, 2);
    push_item(ast_pkg::OP_QUERY, 4'd15, 0);
    push_item(ast_pkg::OP_QUERY, 4'd0, 0);

    // random phases across weights and quantum lengths
    push_cfg(ast_pkg::CFG_DECAY_WEIGHT, 32'd57344);
    push_cfg(ast_pkg::CFG_QUANTUM_LENGTH, 32'd4);
    push_random_phase(280);
    push_cfg(ast_pkg::CFG_DECAY_WEIGHT, 32'h0000_FFFF);
    push_cfg(ast_pkg::CFG_QUANTUM_LENGTH, 32'd1);
    push_random_phase(280);
    push_cfg(ast_pkg::CFG_DECAY_WEIGHT, 32'd0);
    push_cfg(ast_pkg::CFG_QUANTUM_LENGTH, 32'd3);
    push_random_phase(280);
    // longest quantum: counts only build, values stay put
    push_cfg(ast_pkg::CFG_DECAY_WEIGHT, 32'($urandom_range(0, 65535)));
    push_cfg(ast_pkg::CFG_QUANTUM_LENGTH, 32'hFFFF_FFFF);
    push_random_phase(280);
    // short length after many ticks
    push_cfg(ast_pkg::CFG_DECAY_WEIGHT, 32'($urandom_range(0, 65535)));
    push_cfg(ast_pkg::CFG_QUANTUM_LENGTH, 32'd2);
    push_random_phase(280);
    push_cfg(ast_pkg::CFG_DECAY_WEIGHT, 32'd1);
    push_cfg(ast_pkg::CFG_QUANTUM_LENGTH, 32'($urandom_range(1, 10)));
    push_random_phase(280);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // let every command go across and every answer come back
    do @(posedge clk);
    while (stim_q.size() != 0 || start || cfg_we || busy || as_answers_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (as_answers_q.size() != 0)
      flag_mismatch($sformatf("%0d query answers never came", as_answers_q.size()));

    $display("run: %0d commands taken, %0d answers checked, %0d register writes",
             items_taken, results_seen, reg_writes);
    $display("run: %0d quantum ends walked, %0d mismatches", quantum_ends, mismatches);
    if (mismatches == 0) begin
      $display("attained_service_tracker_top verification clean");
    end else begin
      $display("attained_service_tracker_top verification failed");
    end
    $finish;
  end

endmodule
